[sv/byte_fifo_can_frame_packer_core_assert.svh]
// Assertion macros used by the frame packer controller.
// FCP_ASSERT_IMP: same-cycle implication; FCP_ASSERT_NXT: next-cycle implication.
`ifndef BYTE_FIFO_CAN_FRAME_PACKER_CORE_ASSERT_SVH
`define BYTE_FIFO_CAN_FRAME_PACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame packer assertion failed");
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame packer assertion failed");
`else
`define FCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/fcp_pkg.sv]
`default_nettype none

package fcp_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int FRAME_MAX     = 8;
    localparam int BYTE_W        = 8;
    localparam int ID_W          = 11;
    localparam int LEN_W         = 4;
    localparam int FILL_W        = 8;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SEND  = 1'b1;

    typedef logic [FRAME_MAX-1:0][BYTE_W-1:0] t_frame;

    typedef struct packed {
        logic              done;
        logic              frame_valid;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        t_frame            frame_data;
        logic [FILL_W-1:0] fill_level;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_cmd;

endpackage

`default_nettype wire

[sv/byte_fifo_can_frame_packer_core.sv]
// Byte ring buffer that packs its oldest bytes into CAN frames.
//
// Command channel: raise start with i_mode and i_data_byte; the command is
// taken at a rising edge where start is high and busy is low. i_mode = 0
// appends i_data_byte, i_mode = 1 asks for one frame of up to eight bytes.
// Every command returns exactly one result beat, flagged by o_result_valid
// for a single cycle; the receiver cannot hold it off, so sample it then.
//
// Timing: a write, or a transmit that sends nothing (empty buffer or a zero
// identifier), gives its beat in the cycle after acceptance and busy stays
// low, so such commands may follow every cycle. A transmit of n bytes
// (1..8) holds busy while the gather state reads its bytes through the
// store, which has one port and yields one registered byte per cycle;
// its beat leaves through the result register once the last byte is in.
//
// Configuration: i_send_id_we writes i_send_id; write it only while idle.
// Reset clears both pointers, the identifier, the state, r_cnt and r_pend;
// the byte store is not cleared, since reads never pass the fill level.
`default_nettype none

module byte_fifo_can_frame_packer_core #(
    parameter int DEPTH = fcp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_mode,
    input  wire logic [fcp_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                        i_send_id_we,
    input  wire logic [fcp_pkg::ID_W-1:0]    i_send_id,
    output logic                             o_result_valid,
    output logic                             o_frame_valid,
    output logic      [fcp_pkg::ID_W-1:0]    o_frame_id,
    output logic      [fcp_pkg::LEN_W-1:0]   o_frame_len,
    output logic      [63:0]                 o_frame_data,
    output logic      [fcp_pkg::FILL_W-1:0]  o_fill_level,
    output logic                             o_overflow
);

    localparam int PW = $clog2(DEPTH);

    // identifier register; zero blocks transmission
    logic [fcp_pkg::ID_W-1:0]   r_send_id;

    fcp_pkg::t_result           res;
    fcp_pkg::t_mem_cmd          mem_cmd;
    logic [PW-1:0]              mem_addr;
    logic [fcp_pkg::BYTE_W-1:0] mem_wdata;
    logic [fcp_pkg::BYTE_W-1:0] mem_rdata;

    // result beat register: parts the controller from the result ports
    logic                       r_out_vld;
    fcp_pkg::t_result           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_id <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_send_id_we) begin
                r_send_id <= i_send_id;
            end
            r_out_vld <= res.done;
        end
    end

    // payload of the beat: hold the last value between beats
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_out <= res;
        end
    end

    fcp_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_send_id   (r_send_id),
        .o_busy      (busy),
        .o_res       (res),
        .o_mem_cmd   (mem_cmd),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    fcp_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_result_valid = r_out_vld;
    assign o_frame_valid  = r_out.frame_valid;
    assign o_frame_id     = r_out.frame_id;
    assign o_frame_len    = r_out.frame_len;
    assign o_frame_data   = r_out.frame_data;
    assign o_fill_level   = r_out.fill_level;
    assign o_overflow     = r_out.overflow;

endmodule

`default_nettype wire

[sv/fcp_store.sv]
`default_nettype none

module fcp_store #(
    parameter int DEPTH = fcp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire fcp_pkg::t_mem_cmd           i_cmd,
    input  wire logic [$clog2(DEPTH)-1:0]    i_addr,
    input  wire logic [fcp_pkg::BYTE_W-1:0]  i_wdata,
    output logic      [fcp_pkg::BYTE_W-1:0]  o_rdata
);

    logic [fcp_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [fcp_pkg::BYTE_W-1:0] r_rdata;

    // single port: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/fcp_ctrl.sv]
`default_nettype none

module fcp_ctrl #(
    parameter int DEPTH = fcp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_mode,
    input  wire logic [fcp_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [fcp_pkg::ID_W-1:0]    i_send_id,
    output logic                             o_busy,
    output fcp_pkg::t_result                 o_res,
    output fcp_pkg::t_mem_cmd                o_mem_cmd,
    output logic      [$clog2(DEPTH)-1:0]    o_mem_addr,
    output logic      [fcp_pkg::BYTE_W-1:0]  o_mem_wdata,
    input  wire logic [fcp_pkg::BYTE_W-1:0]  i_mem_rdata
);

`include "byte_fifo_can_frame_packer_core_assert.svh"

    localparam int PW = $clog2(DEPTH);
    localparam int SW = $clog2(fcp_pkg::FRAME_MAX);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_GATHER = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [PW-1:0]                   r_wp, n_wp;
    logic [PW-1:0]                   r_rp, n_rp;
    logic [PW-1:0]                   r_raddr, n_raddr;
    logic [fcp_pkg::LEN_W-1:0]       r_len, n_len;
    logic [fcp_pkg::LEN_W-1:0]       r_cnt, n_cnt;
    logic                            r_pend, n_pend;
    logic [SW-1:0]                   r_slot, n_slot;
    fcp_pkg::t_frame                 r_data, n_data;

    logic [PW-1:0]                   held;
    logic [PW-1:0]                   held_after;
    logic                            accept;
    logic                            finish;

    function automatic logic [PW-1:0] f_held(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
        logic [PW:0] d;
        d = {1'b0, wp} - {1'b0, rp};
        if (wp < rp) begin
            d = d + (PW+1)'(DEPTH);
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign held       = f_held(r_wp, r_rp);
    assign held_after = f_held(r_wp, r_raddr);
    assign accept     = i_start && (r_state == S_IDLE);
    assign finish     = (r_state == S_GATHER) && (r_cnt == r_len) && !r_pend;
    assign o_busy     = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_raddr     = r_raddr;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_slot      = r_slot;
        n_data      = r_data;
        o_res       = '0;
        o_mem_cmd   = '0;
        o_mem_addr  = r_wp;
        o_mem_wdata = i_data_byte;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == fcp_pkg::MODE_WRITE) begin
                        o_res.done = 1'b1;
                        if (held == PW'(DEPTH - 1)) begin
                            // full: drop the byte
                            o_res.overflow   = 1'b1;
                            o_res.fill_level = fcp_pkg::FILL_W'(held);
                        end else begin
                            o_mem_cmd.we     = 1'b1;
                            n_wp             = f_inc(r_wp);
                            o_res.fill_level = fcp_pkg::FILL_W'(held + PW'(1));
                        end
                    end else if ((held != '0) && (i_send_id != '0)) begin
                        n_state = S_GATHER;
                        n_len   = (held > PW'(fcp_pkg::FRAME_MAX))
                                ? fcp_pkg::LEN_W'(fcp_pkg::FRAME_MAX)
                                : fcp_pkg::LEN_W'(held);
                        n_cnt   = '0;
                        n_pend  = 1'b0;
                        n_raddr = r_rp;
                        n_data  = '0;
                    end else begin
                        o_res.done       = 1'b1;
                        o_res.fill_level = fcp_pkg::FILL_W'(held);
                    end
                end
            end
            S_GATHER: begin
                o_mem_addr = r_raddr;
                if (r_cnt != r_len) begin
                    o_mem_cmd.re = 1'b1;
                    n_raddr      = f_inc(r_raddr);
                    n_cnt        = r_cnt + fcp_pkg::LEN_W'(1);
                    n_pend       = 1'b1;
                    n_slot       = r_cnt[SW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_data[r_slot] = i_mem_rdata;
                end
                if (finish) begin
                    o_res.done        = 1'b1;
                    o_res.frame_valid = 1'b1;
                    o_res.frame_id    = i_send_id;
                    o_res.frame_len   = r_len;
                    o_res.frame_data  = r_data;
                    o_res.fill_level  = fcp_pkg::FILL_W'(held_after);
                    n_rp              = r_raddr;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        r_len   <= n_len;
        r_slot  <= n_slot;
        r_data  <= n_data;
    end

    `FCP_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, o_mem_cmd.we, !o_mem_cmd.re && (r_state == S_IDLE))
    `FCP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == S_GATHER, (r_cnt <= r_len) && (r_len != '0))
    `FCP_ASSERT_IMP(a_frame_len, i_clk, i_rst_n, o_res.frame_valid, o_res.done && (o_res.frame_len != '0) && (o_res.frame_len <= fcp_pkg::LEN_W'(fcp_pkg::FRAME_MAX)))
    `FCP_ASSERT_NXT(a_finish_idle, i_clk, i_rst_n, finish, (r_state == S_IDLE) && (r_rp == $past(r_raddr)))
    `FCP_ASSERT_IMP(a_ptr_range, i_clk, i_rst_n, 1'b1, (r_rp <= PW'(DEPTH - 1)) && (r_wp <= PW'(DEPTH - 1)))

endmodule

`default_nettype wire
